// ===== rtl/lsa_pkg.sv =====
// Shared types and constants for the leased sequence allocator.
`default_nettype none
package lsa_pkg;

    localparam int unsigned SEQ_W   = 64;
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned STEP_W  = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned M_TDATA_W = 136;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'd10000;

    // register index taken from the word address
    localparam logic [0:0] REG_BLOCK_STEP = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC       = 3'd0,
        KIND_REFILL_DONE = 3'd1,
        KIND_SET_LEASE   = 3'd2,
        KIND_CLEAR_LEASE = 3'd3,
        KIND_LOAD_SEQ    = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EXPIRED  = 2'd1,
        ST_RETRY    = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEQ_W-1:0]  seq;
        logic              fetch_request;
        logic [SEQ_W-1:0]  fetch_base;
        logic              lease_valid;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/lsa_core.sv =====
// Allocator state and the next-state update for one item.
`default_nettype none
module lsa_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [lsa_pkg::KIND_W-1:0]   kind,
    input  wire logic [lsa_pkg::TIME_W-1:0]   now_ms,
    input  wire logic [lsa_pkg::SEQ_W-1:0]    value,
    input  wire logic [lsa_pkg::STEP_W-1:0]   block_step,
    output lsa_pkg::result_t                  result
);

    logic [lsa_pkg::SEQ_W-1:0]  current_seq_reg, current_seq_next;
    logic [lsa_pkg::SEQ_W-1:0]  ceiling_seq_reg, ceiling_seq_next;
    logic [lsa_pkg::TIME_W-1:0] lease_expiry_reg, lease_expiry_next;
    logic                       refill_pending_reg, refill_pending_next;

    logic [lsa_pkg::SEQ_W:0]    room;
    logic                       exhausted;
    logic                       ceil_ge_step;
    logic [lsa_pkg::STEP_W:0]   half_p1;
    logic                       near_top;
    logic                       need_fetch;
    logic                       lease_ok;
    logic [lsa_pkg::SEQ_W-1:0]  seq_inc;

    // ceiling - current; borrow or zero means the block is used up
    assign room         = {1'b0, ceiling_seq_reg} - {1'b0, current_seq_reg};
    assign exhausted    = room[lsa_pkg::SEQ_W] || (room[lsa_pkg::SEQ_W-1:0] == '0);
    assign ceil_ge_step = ceiling_seq_reg >= {32'd0, block_step};
    assign half_p1      = {2'b00, block_step[lsa_pkg::STEP_W-1:1]} + 33'd1;
    // current+1 >= ceiling - step/2  <=>  ceiling - current <= step/2 + 1
    assign near_top     = !exhausted && ceil_ge_step &&
                          (room[lsa_pkg::SEQ_W-1:0] <= {31'd0, half_p1});
    assign need_fetch   = exhausted || near_top;
    assign lease_ok     = lease_expiry_reg > now_ms;
    assign seq_inc      = current_seq_reg + 64'd1;

    always_comb begin
        current_seq_next     = current_seq_reg;
        ceiling_seq_next     = ceiling_seq_reg;
        lease_expiry_next    = lease_expiry_reg;
        refill_pending_next  = refill_pending_reg;
        result.status        = lsa_pkg::ST_OK;
        result.seq           = '0;
        result.fetch_request = 1'b0;
        result.fetch_base    = '0;
        case (kind)
            lsa_pkg::KIND_ALLOC: begin
                if (!lease_ok) begin
                    result.status = lsa_pkg::ST_EXPIRED;
                end else begin
                    if (need_fetch && !refill_pending_reg) begin
                        refill_pending_next  = 1'b1;
                        result.fetch_request = 1'b1;
                        result.fetch_base    = ceiling_seq_reg;
                    end
                    if (exhausted) begin
                        result.status = lsa_pkg::ST_RETRY;
                    end else begin
                        current_seq_next = seq_inc;
                        result.seq       = seq_inc;
                    end
                end
            end
            lsa_pkg::KIND_REFILL_DONE: begin
                refill_pending_next = 1'b0;
                if (value != '0 && value > ceiling_seq_reg) begin
                    ceiling_seq_next = value;
                end else begin
                    result.status = lsa_pkg::ST_REJECTED;
                end
            end
            lsa_pkg::KIND_SET_LEASE: begin
                lease_expiry_next = value[lsa_pkg::TIME_W-1:0];
            end
            lsa_pkg::KIND_CLEAR_LEASE: begin
                lease_expiry_next = '0;
            end
            lsa_pkg::KIND_LOAD_SEQ: begin
                current_seq_next = value;
                ceiling_seq_next = value;
            end
            default: begin
            end
        endcase
        result.lease_valid = lease_expiry_next > now_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_seq_reg    <= '0;
            ceiling_seq_reg    <= '0;
            lease_expiry_reg   <= '0;
            refill_pending_reg <= 1'b0;
        end else if (en) begin
            current_seq_reg    <= current_seq_next;
            ceiling_seq_reg    <= ceiling_seq_next;
            lease_expiry_reg   <= lease_expiry_next;
            refill_pending_reg <= refill_pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/leased_sequence_allocator.sv =====
// Leased sequence allocator: input register, update logic, result register.
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result is not stalled; the state update is
// one register-to-register pass, so each item sees the state left by the item before it.
// s_tready stays high while the result register is free or being drained.
// Reset (aresetn low, synchronous): state cleared, block_step = 10000, no item held.
`default_nettype none
module leased_sequence_allocator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lsa_pkg::APB_AW-1:0]       paddr,
    input  wire logic [lsa_pkg::APB_DW-1:0]       pwdata,
    output logic      [lsa_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready,
    // item input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lsa_pkg::S_TDATA_W-1:0]    s_tdata,  // now_ms[62:0], value[126:63], pad
    input  wire logic [lsa_pkg::KIND_W-1:0]       s_tuser,  // kind[2:0]
    // result output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [lsa_pkg::M_TDATA_W-1:0]    m_tdata,  // seq[63:0], fetch_request[64],
                                                            // fetch_base[128:65],
                                                            // lease_valid[129], pad
    output logic      [lsa_pkg::STAT_W-1:0]       m_tuser   // status[1:0]
);

    logic [lsa_pkg::STEP_W-1:0]    block_step_reg;
    logic                          cfg_wr;

    logic                          in_valid_reg, in_valid_next;
    logic [lsa_pkg::KIND_W-1:0]    in_kind_reg;
    logic [lsa_pkg::TIME_W-1:0]    in_now_reg;
    logic [lsa_pkg::SEQ_W-1:0]     in_value_reg;
    logic                          s_take;
    logic                          advance;

    logic                          out_valid_reg, out_valid_next;
    lsa_pkg::result_t              out_res_reg;
    lsa_pkg::result_t              core_res;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_step_reg <= lsa_pkg::STEP_RESET;
        end else if (cfg_wr && paddr[lsa_pkg::APB_AW-1:2] == lsa_pkg::REG_BLOCK_STEP) begin
            block_step_reg <= pwdata;
        end
    end

    always_comb begin
        if (paddr[lsa_pkg::APB_AW-1:2] == lsa_pkg::REG_BLOCK_STEP) begin
            prdata = block_step_reg;
        end else begin
            prdata = '0;
        end
    end

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_kind_reg  <= s_tuser;
            in_now_reg   <= s_tdata[62:0];
            in_value_reg <= s_tdata[126:63];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    lsa_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .kind       (in_kind_reg),
        .now_ms     (in_now_reg),
        .value      (in_value_reg),
        .block_step (block_step_reg),
        .result     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {6'd0,
                       out_res_reg.lease_valid,
                       out_res_reg.fetch_base,
                       out_res_reg.fetch_request,
                       out_res_reg.seq};

endmodule
`default_nettype wire

// ===== rtl/lsa_checker.sv =====
// Port-level assertions for the leased sequence allocator, bound to the top level.
`default_nettype none
module lsa_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lsa_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [lsa_pkg::STAT_W-1:0]    m_tuser
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // seq is nonzero only on a successful alloc
    a_seq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != lsa_pkg::ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("seq set on failed item");

    a_base_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[64] |-> m_tdata[128:65] == 64'd0)
        else $error("fetch_base without fetch_request");

    a_fetch_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tuser == lsa_pkg::ST_OK || m_tuser == lsa_pkg::ST_RETRY)
        else $error("fetch request on non-alloc result");

endmodule

bind leased_sequence_allocator lsa_checker u_lsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== bench/leased_sequence_allocator_test.sv =====
// Self-checking stream testbench for the leased sequence allocator.
`default_nettype none
module leased_sequence_allocator_test;

    typedef struct {
        logic [lsa_pkg::KIND_W-1:0] kind;
        logic [lsa_pkg::TIME_W-1:0] now_ms;
        logic [lsa_pkg::SEQ_W-1:0]  value;
    } alloc_item_t;

    localparam logic [lsa_pkg::TIME_W-1:0] TIME_MAX = {lsa_pkg::TIME_W{1'b1}};
    localparam logic [lsa_pkg::SEQ_W-1:0]  SEQ_MAX  = {lsa_pkg::SEQ_W{1'b1}};
    localparam logic [lsa_pkg::APB_AW-1:0] STEP_ADDR = {lsa_pkg::REG_BLOCK_STEP, 2'b00};
    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [lsa_pkg::APB_AW-1:0]    paddr = '0;
    logic [lsa_pkg::APB_DW-1:0]    pwdata = '0;
    logic [lsa_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lsa_pkg::S_TDATA_W-1:0] s_tdata = '0;  // now_ms[62:0], value[126:63], pad
    logic [lsa_pkg::KIND_W-1:0]    s_tuser = '0;  // kind[2:0]
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lsa_pkg::M_TDATA_W-1:0] m_tdata;       // seq[63:0], fetch_request[64],
                                                  // fetch_base[128:65], lease_valid[129], pad
    logic [lsa_pkg::STAT_W-1:0]    m_tuser;       // status[1:0]

    leased_sequence_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // predictor copy of the allocator state and its register
    logic [lsa_pkg::SEQ_W-1:0]  cur_seq = '0;
    logic [lsa_pkg::SEQ_W-1:0]  ceil_seq = '0;
    logic [lsa_pkg::TIME_W-1:0] lease_exp = '0;
    logic                       refill_pend = 1'b0;
    logic [lsa_pkg::STEP_W-1:0] cfg_step = lsa_pkg::STEP_RESET;

    alloc_item_t       pending_items[$];
    lsa_pkg::result_t  expected_results[$];
    alloc_item_t offered_item = '{kind: '0, now_ms: '0, value: '0};
    logic        holding = 1'b0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    logic        idle_on = 1'b1;
    logic        hold_request = 1'b0;
    logic        hold_off = 1'b0;
    int          mismatch_count = 0;

    function automatic lsa_pkg::result_t step_allocator(alloc_item_t it);
        lsa_pkg::result_t          r;
        logic                      exhausted;
        logic                      need;
        logic [lsa_pkg::SEQ_W-1:0] next;
        r = '0;
        case (it.kind)
            lsa_pkg::KIND_ALLOC: begin
                if (lease_exp <= it.now_ms) begin
                    r.status = lsa_pkg::ST_EXPIRED;
                end else begin
                    exhausted = cur_seq >= ceil_seq;
                    need = exhausted;
                    next = cur_seq + 64'd1;
                    // watermark only applies once the ceiling covers a whole block
                    if (!exhausted && ceil_seq >= {32'd0, cfg_step} &&
                        next >= ceil_seq - {33'd0, cfg_step[lsa_pkg::STEP_W-1:1]})
                        need = 1'b1;
                    if (need && !refill_pend) begin
                        refill_pend = 1'b1;
                        r.fetch_request = 1'b1;
                        r.fetch_base = ceil_seq;
                    end
                    if (exhausted) begin
                        r.status = lsa_pkg::ST_RETRY;
                    end else begin
                        cur_seq = next;
                        r.seq = next;
                    end
                end
            end
            lsa_pkg::KIND_REFILL_DONE: begin
                refill_pend = 1'b0;
                if (it.value != 64'd0 && it.value > ceil_seq)
                    ceil_seq = it.value;
                else
                    r.status = lsa_pkg::ST_REJECTED;
            end
            lsa_pkg::KIND_SET_LEASE: lease_exp = it.value[lsa_pkg::TIME_W-1:0];
            lsa_pkg::KIND_CLEAR_LEASE: lease_exp = '0;
            lsa_pkg::KIND_LOAD_SEQ: begin
                cur_seq = it.value;
                ceil_seq = it.value;
            end
            default: ;
        endcase
        r.lease_valid = lease_exp > it.now_ms;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [lsa_pkg::SEQ_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string field, logic [lsa_pkg::SEQ_W-1:0] got,
                                   logic [lsa_pkg::SEQ_W-1:0] want);
        if (mismatch_count < 100)
            $display("mismatch %s: got %h expected %h", field, got, want);
        mismatch_count++;
    endtask

    task automatic push_item(logic [lsa_pkg::KIND_W-1:0] kind,
                             logic [lsa_pkg::TIME_W-1:0] now_ms,
                             logic [lsa_pkg::SEQ_W-1:0] value);
        alloc_item_t it;
        it.kind = kind;
        it.now_ms = now_ms;
        it.value = value;
        pending_items.push_back(it);
    endtask

    // sender: one item offered at a time, random gap after each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            holding = 1'b0;
            tx_gap = 0;
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(step_allocator(offered_item));
                holding = 1'b0;
                tx_gap = pick_gap();
            end
            if (!holding) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_items.size() > 0) begin
                    offered_item = pending_items.pop_front();
                    holding = 1'b1;
                end
            end
            s_tvalid <= holding;
            s_tdata <= {1'b0, offered_item.value, offered_item.now_ms};
            s_tuser <= offered_item.kind;
        end
    end

    // receiver: checks each accepted result against the oldest prediction
    always @(posedge aclk) begin
        lsa_pkg::result_t want;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[63:0] !== want.seq)
                    report_mismatch("seq", m_tdata[63:0], want.seq);
                if (m_tdata[64] !== want.fetch_request)
                    report_mismatch("fetch_request", 64'(m_tdata[64]), 64'(want.fetch_request));
                if (m_tdata[128:65] !== want.fetch_base)
                    report_mismatch("fetch_base", m_tdata[128:65], want.fetch_base);
                if (m_tdata[129] !== want.lease_valid)
                    report_mismatch("lease_valid", 64'(m_tdata[129]), 64'(want.lease_valid));
            end
        end
        if (rx_stall > 0)
            rx_stall--;
        else if ($urandom_range(0, 3) == 0)
            rx_stall = pick_gap();
        m_tready <= aresetn && !hold_off && rx_stall == 0;
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_request);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || holding || expected_results.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_block_step(logic [lsa_pkg::STEP_W-1:0] v);
        logic [lsa_pkg::APB_DW-1:0] readback;
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= STEP_ADDR;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_step = v;
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== v)
            report_mismatch("prdata", 64'(readback), 64'(v));
    endtask

    task automatic queue_directed();
        push_item(lsa_pkg::KIND_ALLOC, '0, '0);                 // no lease yet
        push_item(lsa_pkg::KIND_SET_LEASE, '0, SEQ_MAX);         // top bit of value dropped
        push_item(lsa_pkg::KIND_ALLOC, TIME_MAX - 63'd1, '0);    // empty block: retry plus refill
        push_item(lsa_pkg::KIND_ALLOC, 63'd5, '0);               // refill already pending
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd6, '0);         // zero ceiling rejected
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd7, 64'd20000);
        push_item(lsa_pkg::KIND_ALLOC, 63'd8, '0);
        push_item(lsa_pkg::KIND_LOAD_SEQ, 63'd9, 64'd14998);
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd10, 64'd20000);
        push_item(lsa_pkg::KIND_ALLOC, 63'd11, '0);
        push_item(lsa_pkg::KIND_ALLOC, 63'd12, '0);              // crosses the watermark
        push_item(lsa_pkg::KIND_ALLOC, 63'd13, '0);
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd14, 64'd100);   // lower ceiling rejected
        push_item(lsa_pkg::KIND_LOAD_SEQ, 63'd15, '0);
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd16, 64'd50);    // ceiling below one block
        push_item(lsa_pkg::KIND_ALLOC, 63'd17, '0);
        push_item(lsa_pkg::KIND_LOAD_SEQ, 63'd18, SEQ_MAX - 64'd1);
        push_item(lsa_pkg::KIND_REFILL_DONE, 63'd19, SEQ_MAX);
        push_item(lsa_pkg::KIND_ALLOC, 63'd20, '0);              // hands out the top number
        push_item(lsa_pkg::KIND_ALLOC, 63'd21, '0);              // top of range, no wrap
        push_item(lsa_pkg::KIND_CLEAR_LEASE, TIME_MAX, SEQ_MAX);
        push_item(lsa_pkg::KIND_ALLOC, TIME_MAX, SEQ_MAX);
        push_item(lsa_pkg::KIND_SET_LEASE, '0, 64'd100);
        push_item(lsa_pkg::KIND_ALLOC, 63'd99, '0);
        push_item(lsa_pkg::KIND_ALLOC, 63'd100, '0);             // lease runs out exactly
        push_item(3'd5, TIME_MAX, SEQ_MAX);
        push_item(3'd6, 63'd1, '0);
        push_item(3'd7, 63'd50, 64'h5555_aaaa_5555_aaaa);
    endtask

    // well-formed session: load, lease, refill, then mostly allocs with some noise
    task automatic queue_session(int count);
        logic [lsa_pkg::TIME_W-1:0] t;
        logic [lsa_pkg::SEQ_W-1:0]  ceil_guess;
        logic [lsa_pkg::SEQ_W-1:0]  r64;
        int                         pick;
        r64 = rand64();
        t = ($urandom_range(0, 3) == 0) ? r64[lsa_pkg::TIME_W-1:0]
                                         : 63'($urandom_range(0, 100000));
        ceil_guess = {32'd0, cfg_step} * 64'($urandom_range(1, 4));
        push_item(lsa_pkg::KIND_LOAD_SEQ, t, ceil_guess);
        push_item(lsa_pkg::KIND_SET_LEASE, t, {1'b0, t + 63'($urandom_range(50, 400))});
        ceil_guess = ceil_guess + 64'($urandom_range(1, 60));
        push_item(lsa_pkg::KIND_REFILL_DONE, t, ceil_guess);
        for (int n = 0; n < count; n++) begin
            t = t + 63'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                push_item(lsa_pkg::KIND_ALLOC, t, rand64());
            end else if (pick < 74) begin
                case ($urandom_range(0, 9))
                    0: push_item(lsa_pkg::KIND_REFILL_DONE, t, '0);
                    1: push_item(lsa_pkg::KIND_REFILL_DONE, t,
                                 ceil_guess - 64'($urandom_range(0, 30)));
                    2: begin
                        ceil_guess = ceil_guess + {32'd0, cfg_step};
                        push_item(lsa_pkg::KIND_REFILL_DONE, t, ceil_guess);
                    end
                    default: begin
                        ceil_guess = ceil_guess + 64'($urandom_range(1, 60));
                        push_item(lsa_pkg::KIND_REFILL_DONE, t, ceil_guess);
                    end
                endcase
            end else if (pick < 82) begin
                push_item(lsa_pkg::KIND_SET_LEASE, t, {1'b0, t + 63'($urandom_range(0, 300))});
            end else if (pick < 84) begin
                push_item(lsa_pkg::KIND_CLEAR_LEASE, t, rand64());
            end else if (pick < 88) begin
                ceil_guess = ceil_guess - 64'($urandom_range(0, 40));
                push_item(lsa_pkg::KIND_LOAD_SEQ, t, ceil_guess);
            end else if (pick < 92) begin
                r64 = rand64();
                push_item(3'($urandom_range(5, 7)), r64[lsa_pkg::TIME_W-1:0], rand64());
            end else begin
                r64 = rand64();
                push_item(3'($urandom_range(0, 7)), r64[lsa_pkg::TIME_W-1:0], rand64());
            end
        end
    endtask

    initial begin
        logic [lsa_pkg::STEP_W-1:0] steps[7];
        steps[0] = lsa_pkg::STEP_RESET;
        steps[1] = 32'd16;
        steps[2] = 32'd0;
        steps[3] = 32'd1;
        steps[4] = 32'hffff_ffff;
        steps[5] = 32'($urandom_range(2, 200));
        steps[6] = $urandom;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        queue_directed();
        wait_idle();
        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0)
                write_block_step(steps[ph]);
            idle_on = (ph != 4);
            if (ph == 2)
                hold_request = 1'b1;
            queue_session(50);
            queue_session(50);
            wait_idle();
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
